/* rtl/torcs_pkg.sv */
// Shared constants, codes and types of the twelve-opcode core.
package torcs_pkg;

   localparam int MEM_WORDS = 2048;
   localparam int NUM_REGS  = 32;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int REG_AW    = $clog2(NUM_REGS);
   localparam int WORD_W    = 32;
   localparam int PC_W      = 28;
   localparam int ADDR_W    = 11;
   localparam int PLEN_W    = 11;
   localparam int CSR_AW    = 3;
   localparam int CSR_IW    = CSR_AW - 2;
   localparam int IMM_W     = 18;
   localparam int SHAMT_W   = 13;

   typedef enum logic [1:0] {
      KIND_WRITE_MEM = 2'd0,
      KIND_EXEC      = 2'd1,
      KIND_READ_MEM  = 2'd2,
      KIND_READ_REG  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_MOVI = 4'd3,
      OP_JEQ  = 4'd4,
      OP_AND  = 4'd5,
      OP_XORI = 4'd6,
      OP_JMP  = 4'd7,
      OP_LSL  = 4'd8,
      OP_LSR  = 4'd9,
      OP_MOVR = 4'd10,
      OP_MOVM = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ONE,
      ST_DEC,
      ST_EXE,
      ST_LOAD
   } state_type;

   localparam logic [CSR_IW-1:0] CSR_PROGRAM_LENGTH = CSR_IW'(0);

   typedef struct packed {
      logic [1:0]               kind;
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          pc;
      logic signed [WORD_W-1:0] read_value;
      logic                     reg_write;
      logic [REG_AW-1:0]        dest_reg;
      logic signed [WORD_W-1:0] dest_value;
      logic                     mem_write;
      logic [ADDR_W-1:0]        mem_address;
      logic                     halted;
      logic                     fault;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [WORD_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] idx;
      logic [WORD_W-1:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic              wb;
      logic [WORD_W-1:0] res;
      logic [PC_W-1:0]   next_pc;
      logic              mem_op;
      logic              is_load;
      logic              is_store;
      logic [WORD_W-1:0] ea;
      logic              ea_fault;
      logic [REG_AW-1:0] r1;
   } alu_out_type;

   function automatic logic [MEM_AW-1:0] mem_idx(input logic [WORD_W-1:0] v);
      return v[MEM_AW-1:0];
   endfunction

endpackage

/* rtl/torcs_main_mem.sv */
// Unified word memory: one write port, one registered read port with write bypass.
module torcs_main_mem
   import torcs_pkg::*;
(
   input  logic              clock,
   input  mem_wr_type        wr,
   input  logic              re,
   input  logic [MEM_AW-1:0] raddr,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [MEM_WORDS];
   logic [WORD_W-1:0] ram_q_ff;
   logic              byp_ff;
   logic [WORD_W-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         ram_q_ff    <= mem[raddr];
         byp_ff      <= wr.en && (wr.addr == raddr);
         byp_data_ff <= wr.data;
      end
   end

   assign rdata = byp_ff ? byp_data_ff : ram_q_ff;

endmodule

/* rtl/torcs_reg_file.sv */
// Register file: two mirrored synchronous arrays giving three read ports.
module torcs_reg_file
   import torcs_pkg::*;
(
   input  logic              clock,
   input  rf_wr_type         wr,
   input  logic              re,
   input  logic [REG_AW-1:0] ra,
   input  logic [REG_AW-1:0] rb,
   input  logic [REG_AW-1:0] rc,
   output logic [WORD_W-1:0] rd_a,
   output logic [WORD_W-1:0] rd_b,
   output logic [WORD_W-1:0] rd_c
);

   logic [WORD_W-1:0] rf_a [NUM_REGS];
   logic [WORD_W-1:0] rf_b [NUM_REGS];
   logic [WORD_W-1:0] qa_ff, qb_ff, qc_ff;
   logic              byp_a_ff, byp_b_ff, byp_c_ff;
   logic [WORD_W-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rf_a[wr.idx] <= wr.data;
         rf_b[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         qa_ff       <= rf_a[ra];
         qb_ff       <= rf_a[rb];
         qc_ff       <= rf_b[rc];
         byp_a_ff    <= wr.en && (wr.idx == ra);
         byp_b_ff    <= wr.en && (wr.idx == rb);
         byp_c_ff    <= wr.en && (wr.idx == rc);
         byp_data_ff <= wr.data;
      end
   end

   assign rd_a = byp_a_ff ? byp_data_ff : qa_ff;
   assign rd_b = byp_b_ff ? byp_data_ff : qb_ff;
   assign rd_c = byp_c_ff ? byp_data_ff : qc_ff;

endmodule

/* rtl/torcs_alu.sv */
// Instruction decode, ALU, branch target and effective address.
module torcs_alu
   import torcs_pkg::*;
(
   input  logic [WORD_W-1:0] instr,
   input  logic [PC_W-1:0]   pc,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   input  logic [WORD_W-1:0] c,
   output alu_out_type       out
);

   logic [WORD_W-1:0]  imm;
   logic [SHAMT_W-1:0] sh;
   logic [PC_W-1:0]    pc_inc;

   always_comb begin
      imm    = {{(WORD_W-IMM_W){instr[IMM_W-1]}}, instr[IMM_W-1:0]};
      sh     = instr[SHAMT_W-1:0];
      pc_inc = pc + PC_W'(1);

      out          = '0;
      out.r1       = instr[27:23];
      out.next_pc  = pc_inc;
      out.ea       = a + imm;
      out.ea_fault = out.ea >= WORD_W'(MEM_WORDS);

      case (op_type'(instr[31:28]))
         OP_ADD: begin
            out.res = a + b;
            out.wb  = 1'b1;
         end
         OP_SUB: begin
            out.res = a - b;
            out.wb  = 1'b1;
         end
         OP_MUL: begin
            out.res = a * b;
            out.wb  = 1'b1;
         end
         OP_MOVI: begin
            out.res = imm;
            out.wb  = 1'b1;
         end
         OP_JEQ: begin
            if (c == a) begin
               out.next_pc = pc_inc + imm[PC_W-1:0];
            end
         end
         OP_AND: begin
            out.res = a & b;
            out.wb  = 1'b1;
         end
         OP_XORI: begin
            out.res = a ^ imm;
            out.wb  = 1'b1;
         end
         OP_JMP: begin
            out.next_pc = instr[PC_W-1:0];
         end
         OP_LSL: begin
            out.res = (sh < SHAMT_W'(WORD_W)) ? (a << sh[4:0]) : '0;
            out.wb  = 1'b1;
         end
         OP_LSR: begin
            out.res = (sh < SHAMT_W'(WORD_W)) ? (a >> sh[4:0]) : '0;
            out.wb  = 1'b1;
         end
         OP_MOVR: begin
            out.mem_op  = 1'b1;
            out.is_load = 1'b1;
         end
         OP_MOVM: begin
            out.mem_op   = 1'b1;
            out.is_store = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/twelve_op_risc_core_step_core.sv */
// Top level of the twelve-opcode core: sequencer, PC, config register and result register.
// After reset the core sweeps the main memory and the register file to zero, one word
// per cycle, with req_ready low; csr writes are taken during the sweep. Memory writes,
// memory reads and register reads may then be issued every cycle while no result is
// held back by rsp_ready. An execute word fetches its instruction on the main memory
// port, reads registers in ST_DEC, then executes and writes back in ST_EXE; MOVR adds
// ST_LOAD, as its data read needs a second pass through the single main memory port. A new word is
// taken in the same cycle that the previous result is loaded into the output register,
// and while an earlier result waits on rsp_ready.
module twelve_op_risc_core_step_core
   import torcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   state_type         state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [PLEN_W-1:0] plen_ff;
   logic [MEM_AW-1:0] clr_cnt_ff;
   req_type           item_ff;
   logic [WORD_W-1:0] instr_ff;
   logic              halt_ff, ffault_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              done, accept, out_free, commit_pc, exec_ok, csr_wr;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_raddr;
   logic [WORD_W-1:0] mem_rdata;
   mem_wr_type        mem_wr;
   rf_wr_type         rf_wr;
   logic              rf_re;
   logic [REG_AW-1:0] rf_ra, rf_rb, rf_rc;
   logic [WORD_W-1:0] rf_rd_a, rf_rd_b, rf_rd_c;
   alu_out_type       alu;

   torcs_main_mem u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   torcs_reg_file u_rf (
      .clock (clock),
      .wr    (rf_wr),
      .re    (rf_re),
      .ra    (rf_ra),
      .rb    (rf_rb),
      .rc    (rf_rc),
      .rd_a  (rf_rd_a),
      .rd_b  (rf_rd_b),
      .rd_c  (rf_rd_c)
   );

   torcs_alu u_alu (
      .instr (instr_ff),
      .pc    (pc_ff),
      .a     (rf_rd_a),
      .b     (rf_rd_c),
      .c     (rf_rd_b),
      .out   (alu)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_AW-1:2] == CSR_PROGRAM_LENGTH);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == CSR_PROGRAM_LENGTH) ? 32'(plen_ff) : '0;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_ok  = !halt_ff && !ffault_ff;

   always_comb begin
      state_in  = state_ff;
      done      = 1'b0;
      commit_pc = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      mem_wr    = '0;
      rf_wr     = '0;
      rf_re     = 1'b0;
      rf_ra     = '0;
      rf_rb     = '0;
      rf_rc     = '0;
      rsp_in    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_cnt_ff;
            rf_wr.en    = 1'b1;
            rf_wr.idx   = clr_cnt_ff[REG_AW-1:0];
            if (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_ONE: begin
            done = out_free;
            case (kind_type'(item_ff.kind))
               KIND_WRITE_MEM: begin
                  rsp_in.fault = 32'(item_ff.address) >= 32'(MEM_WORDS);
                  mem_wr.en    = done && !rsp_in.fault;
                  mem_wr.addr  = mem_idx(32'(item_ff.address));
                  mem_wr.data  = item_ff.data;
               end
               KIND_READ_MEM: begin
                  rsp_in.fault      = 32'(item_ff.address) >= 32'(MEM_WORDS);
                  rsp_in.read_value = rsp_in.fault ? '0 : mem_rdata;
               end
               KIND_READ_REG: begin
                  rsp_in.fault      = 32'(item_ff.address) >= 32'(NUM_REGS);
                  rsp_in.read_value = rsp_in.fault ? '0 : rf_rd_a;
               end
               default: begin
               end
            endcase
         end
         ST_DEC: begin
            rf_re    = 1'b1;
            rf_ra    = mem_rdata[22:18];
            rf_rb    = mem_rdata[27:23];
            rf_rc    = mem_rdata[17:13];
            state_in = ST_EXE;
         end
         ST_EXE: begin
            if (exec_ok && alu.is_load && !alu.ea_fault) begin
               mem_re    = 1'b1;
               mem_raddr = mem_idx(alu.ea);
               commit_pc = 1'b1;
               state_in  = ST_LOAD;
            end else begin
               done               = out_free;
               commit_pc          = done && exec_ok;
               rsp_in.halted      = halt_ff;
               rsp_in.fault       = ffault_ff || (exec_ok && alu.mem_op && alu.ea_fault);
               rsp_in.reg_write   = exec_ok && alu.wb && (alu.r1 != '0);
               rsp_in.dest_reg    = rsp_in.reg_write ? alu.r1 : '0;
               rsp_in.dest_value  = rsp_in.reg_write ? alu.res : '0;
               rsp_in.mem_write   = exec_ok && alu.is_store && !alu.ea_fault;
               rsp_in.mem_address = (exec_ok && alu.mem_op) ? alu.ea[ADDR_W-1:0] : '0;
               rf_wr.en           = done && rsp_in.reg_write;
               rf_wr.idx          = alu.r1;
               rf_wr.data         = alu.res;
               mem_wr.en          = done && rsp_in.mem_write;
               mem_wr.addr        = mem_idx(alu.ea);
               mem_wr.data        = rf_rd_b;
            end
         end
         ST_LOAD: begin
            done               = out_free;
            rsp_in.reg_write   = alu.r1 != '0;
            rsp_in.dest_reg    = rsp_in.reg_write ? alu.r1 : '0;
            rsp_in.dest_value  = rsp_in.reg_write ? mem_rdata : '0;
            rsp_in.mem_address = alu.ea[ADDR_W-1:0];
            rf_wr.en           = done && rsp_in.reg_write;
            rf_wr.idx          = alu.r1;
            rf_wr.data         = mem_rdata;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pc_in     = commit_pc ? alu.next_pc : pc_ff;
      rsp_in.pc = pc_in;

      req_ready = (state_ff == ST_IDLE) || done;
      accept    = req_valid && req_ready;

      if (done) begin
         state_in = ST_IDLE;
      end

      if (accept) begin
         mem_re = 1'b1;
         if (kind_type'(req_data.kind) == KIND_EXEC) begin
            mem_raddr = pc_in[MEM_AW-1:0];
            state_in  = ST_DEC;
         end else begin
            mem_raddr = mem_idx(32'(req_data.address));
            state_in  = ST_ONE;
         end
         if (kind_type'(req_data.kind) == KIND_READ_REG) begin
            rf_re = 1'b1;
            rf_ra = req_data.address[REG_AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + MEM_AW'(1);
         end
         if (csr_wr) begin
            plen_ff <= csr_pwdata[PLEN_W-1:0];
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_DEC) begin
         instr_ff  <= mem_rdata;
         halt_ff   <= pc_ff >= PC_W'(plen_ff);
         ffault_ff <= (pc_ff < PC_W'(plen_ff)) && (pc_ff >= PC_W'(MEM_WORDS));
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/torcs_checker.sv */
// Port-level checks of the core and their binding to the top level.
module torcs_checker
   import torcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("core ready or showing a result right after reset");

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.halted |->
         !rsp_data.reg_write && !rsp_data.mem_write && !rsp_data.fault)
      else $error("halted step changed state");

   a_fault_no_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> !rsp_data.mem_write)
      else $error("store performed on a faulting access");

   a_dest_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_write |->
         (rsp_data.dest_reg == '0) && (rsp_data.dest_value == '0))
      else $error("destination fields set without a register write");

endmodule

bind twelve_op_risc_core_step_core torcs_checker u_torcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* sim/testbench.sv */
// Self-checking testbench of the twelve-opcode core: shadow state predicts each result word.
`timescale 1ns / 1ps

module testbench;
   import torcs_pkg::*;

   localparam int ITEMS          = 1300;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int CHOKE_AFTER    = 400;
   localparam int CHOKE_CYCLES   = 300;
   localparam int MAX_REPORTS    = 40;

   class step_scoreboard;
      logic [WORD_W-1:0] regs [NUM_REGS];
      logic [WORD_W-1:0] mem [MEM_WORDS];
      logic [PC_W-1:0]   pc;
      logic [PLEN_W-1:0] plen;
      rsp_type           pending_results [$];
      int                failures;
      int                checked;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         pc = '0;
         plen = '0;
         failures = 0;
         checked = 0;
      endfunction

      function void note_request(req_type w);
         rsp_type           e;
         logic [WORD_W-1:0] instr, a, b, res, imm, ea;
         logic [3:0]        op;
         logic [4:0]        r1, r2, r3;
         logic [12:0]       sh;
         logic [PC_W-1:0]   nxt;
         logic              wb;
         e = '0;
         wb = 1'b0;
         res = '0;
         case (w.kind)
            KIND_WRITE_MEM: begin
               if (w.address < MEM_WORDS) mem[w.address] = w.data;
               else e.fault = 1'b1;
            end
            KIND_READ_MEM: begin
               if (w.address < MEM_WORDS) e.read_value = mem[w.address];
               else e.fault = 1'b1;
            end
            KIND_READ_REG: begin
               if (w.address < NUM_REGS) e.read_value = regs[w.address[REG_AW-1:0]];
               else e.fault = 1'b1;
            end
            default: begin
               if (pc >= plen) begin
                  e.halted = 1'b1;
               end else if (pc >= MEM_WORDS) begin
                  e.fault = 1'b1;
               end else begin
                  instr = mem[pc[MEM_AW-1:0]];
                  op = instr[31:28];
                  r1 = instr[27:23];
                  r2 = instr[22:18];
                  r3 = instr[17:13];
                  sh = instr[12:0];
                  imm = {{14{instr[17]}}, instr[17:0]};
                  a = regs[r2];
                  b = regs[r3];
                  nxt = pc + 1'b1;
                  case (op)
                     OP_ADD:  begin res = a + b; wb = 1'b1; end
                     OP_SUB:  begin res = a - b; wb = 1'b1; end
                     OP_MUL:  begin res = a * b; wb = 1'b1; end
                     OP_MOVI: begin res = imm; wb = 1'b1; end
                     OP_JEQ:  if (regs[r1] == a) nxt = pc + 1'b1 + imm[PC_W-1:0];
                     OP_AND:  begin res = a & b; wb = 1'b1; end
                     OP_XORI: begin res = a ^ imm; wb = 1'b1; end
                     OP_JMP:  nxt = instr[PC_W-1:0];
                     OP_LSL:  begin res = (sh < 32) ? a << sh : '0; wb = 1'b1; end
                     OP_LSR:  begin res = (sh < 32) ? a >> sh : '0; wb = 1'b1; end
                     OP_MOVR, OP_MOVM: begin
                        ea = a + imm;
                        e.mem_address = ea[ADDR_W-1:0];
                        if (ea >= MEM_WORDS) begin
                           e.fault = 1'b1;
                        end else if (op == OP_MOVR) begin
                           res = mem[ea[MEM_AW-1:0]];
                           wb = 1'b1;
                        end else begin
                           mem[ea[MEM_AW-1:0]] = regs[r1];
                           e.mem_write = 1'b1;
                        end
                     end
                     default: ;
                  endcase
                  if (wb && r1 != 0) begin
                     regs[r1] = res;
                     e.reg_write = 1'b1;
                     e.dest_reg = r1;
                     e.dest_value = res;
                  end
                  pc = nxt;
               end
            end
         endcase
         e.pc = pc;
         pending_results.push_back(e);
      endfunction

      function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected word, expected none, got pc 0x%0h",
                        $time, got.pc);
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (got.pc !== e.pc) report_mismatch("pc", e.pc, got.pc);
         if (got.read_value !== e.read_value)
            report_mismatch("read_value", e.read_value, got.read_value);
         if (got.reg_write !== e.reg_write)
            report_mismatch("reg_write", e.reg_write, got.reg_write);
         if (got.dest_reg !== e.dest_reg)
            report_mismatch("dest_reg", e.dest_reg, got.dest_reg);
         if (got.dest_value !== e.dest_value)
            report_mismatch("dest_value", e.dest_value, got.dest_value);
         if (got.mem_write !== e.mem_write)
            report_mismatch("mem_write", e.mem_write, got.mem_write);
         if (got.mem_address !== e.mem_address)
            report_mismatch("mem_address", e.mem_address, got.mem_address);
         if (got.halted !== e.halted) report_mismatch("halted", e.halted, got.halted);
         if (got.fault !== e.fault) report_mismatch("fault", e.fault, got.fault);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   step_scoreboard sb;
   int             sent;
   int             idle_cycles;
   bit             steady_sender;

   twelve_op_risc_core_step_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_word(kind_type k, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d);
      req_type w;
      int      r;
      int      gap;
      w.kind = k;
      w.address = a;
      w.data = d;
      r = $urandom_range(0, 99);
      if (steady_sender || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      sent++;
   endtask

   // place the word at the current pc when that lies in memory, then run it
   task automatic step_instr(logic [WORD_W-1:0] instr);
      if (sb.pc < MEM_WORDS) send_word(KIND_WRITE_MEM, sb.pc[ADDR_W-1:0], instr);
      send_word(KIND_EXEC, ADDR_W'($urandom), $urandom);
   endtask

   task automatic set_length(logic [31:0] v);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_PROGRAM_LENGTH, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.plen = v[PLEN_W-1:0];
   endtask

   function automatic logic [WORD_W-1:0] next_instruction();
      int          lim;
      logic [3:0]  op;
      logic [4:0]  r1, r2, r3;
      logic [17:0] imm;
      longint      hop;
      lim = int'(sb.plen);
      r1 = 5'($urandom);
      r2 = 5'($urandom);
      r3 = 5'($urandom);
      imm = 18'($urandom);
      // steer back before running off the end of the program
      if (lim != 0 && int'(sb.pc) + 1 >= lim &&
          (int'(sb.pc) + 1 >= 2047 || $urandom_range(0, 19) != 0))
         return {OP_JMP, 28'($urandom_range(0, lim - 1))};
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      case (op)
         OP_JEQ, OP_JMP: begin
            if ($urandom_range(0, 39) == 0 || lim == 0) hop = $urandom_range(0, 2046);
            else hop = $urandom_range(0, lim - 1);
            if (op == OP_JMP) return {op, 28'(hop)};
            if ($urandom_range(0, 1) == 1) r2 = r1;
            hop = hop - (longint'(sb.pc) + 1);
            return {op, r1, r2, 18'(hop)};
         end
         OP_MOVR, OP_MOVM: begin
            if ($urandom_range(0, 1) == 1) r2 = '0;
            hop = longint'($urandom_range(0, 2047)) - longint'($signed(sb.regs[r2]));
            if ($urandom_range(0, 7) != 0 && hop >= -131072 && hop <= 131071)
               imm = 18'(hop);
            return {op, r1, r2, imm};
         end
         OP_MOVI, OP_XORI: return {op, r1, r2, imm};
         default: return {op, r1, r2, r3, ($urandom_range(0, 3) == 0) ?
                          13'($urandom) : 13'($urandom_range(0, 33))};
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("twelve_op_risc_core_step_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      bit choked;
      choked = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!choked && sb.checked >= CHOKE_AFTER) begin
            choked = 1'b1;
            rsp_ready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
         end else if (r < 60) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (r < 95) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 50)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [WORD_W-1:0] prog [16];
      logic [31:0]       length;
      logic [WORD_W-1:0] cur;
      logic [3:0]        cur_op;
      int                ph;
      int                r;
      sb = new();
      sent = 0;
      idle_cycles = 0;
      steady_sender = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(KIND_EXEC, '0, '0);
      send_word(KIND_READ_REG, 11'd31, '0);
      send_word(KIND_READ_REG, 11'd32, '0);
      send_word(KIND_READ_REG, 11'd2047, 32'hFFFF_FFFF);
      send_word(KIND_WRITE_MEM, 11'd2047, 32'h8000_0000);
      send_word(KIND_READ_MEM, 11'd2047, '0);
      send_word(KIND_WRITE_MEM, 11'd0, {OP_MOVI, 5'd5, 5'd0, 18'h3FFFF});
      set_length(32'd1);
      send_word(KIND_EXEC, '0, '0);
      send_word(KIND_EXEC, '0, '0);
      set_length(32'd2047);
      prog = '{{OP_MOVI, 5'd0, 5'd0, 18'd5},
               {OP_MOVI, 5'd6, 5'd0, 18'h1FFFF},
               {OP_ADD, 5'd7, 5'd5, 5'd6, 13'd0},
               {OP_MUL, 5'd9, 5'd6, 5'd6, 13'd0},
               {OP_XORI, 5'd11, 5'd5, 18'h20000},
               {OP_LSL, 5'd12, 5'd5, 5'd5, 13'd31},
               {OP_LSR, 5'd13, 5'd5, 5'd5, 13'd32},
               {OP_LSR, 5'd14, 5'd5, 5'd5, 13'd1},
               {OP_MOVM, 5'd5, 5'd0, 18'd100},
               {OP_MOVR, 5'd15, 5'd0, 18'd100},
               {OP_MOVR, 5'd16, 5'd5, 18'd0},
               {OP_MOVM, 5'd6, 5'd6, 18'h1FFFF},
               {OP_JEQ, 5'd0, 5'd0, 18'd2},
               {OP_JEQ, 5'd5, 5'd6, 18'h3FFF0},
               {4'hF, 28'h0AB_CDEF},
               {OP_JMP, 28'd3}};
      foreach (prog[i]) step_instr(prog[i]);

      for (ph = 0; sent < ITEMS; ph++) begin
         case (ph % 4)
            0: length = 32'd2047;
            1: length = $urandom_range(int'(sb.pc) + 1, 2047);
            2: begin
               length = int'(sb.pc) + 1 + $urandom_range(0, 15);
               if (length > 2047) length = 32'd2047;
            end
            default: length = ($urandom & 32'hFFFF_F800) |
                              $urandom_range(int'(sb.pc) + 1, 2047);
         endcase
         set_length(length);
         steady_sender = (ph % 3 == 2);
         repeat (150) begin
            r = $urandom_range(0, 99);
            cur = sb.mem[sb.pc[MEM_AW-1:0]];
            cur_op = cur[31:28];
            if (r < 55 || (r < 65 && (cur_op == OP_JEQ || cur_op == OP_JMP ||
                                      int'(sb.pc) + 1 >= 2047)))
               step_instr(next_instruction());
            else if (r < 65)
               send_word(KIND_EXEC, ADDR_W'($urandom), $urandom);
            else if (r < 75)
               send_word(KIND_WRITE_MEM, ADDR_W'($urandom), $urandom);
            else if (r < 85)
               send_word(KIND_READ_MEM, ADDR_W'($urandom), $urandom);
            else if (r < 92)
               send_word(KIND_READ_REG, ADDR_W'($urandom), $urandom);
            else
               send_word(KIND_READ_REG, ADDR_W'($urandom_range(0, 31)), $urandom);
         end
      end

      // leave through a jump far past any program, then ask once more
      steady_sender = 1'b0;
      set_length(32'd2047);
      step_instr({OP_JMP, 28'($urandom) | 28'h080_0000});
      send_word(KIND_EXEC, '0, '0);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("twelve_op_risc_core_step_core: match");
      end else begin
         $display("twelve_op_risc_core_step_core: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/torcs_pkg.sv
rtl/torcs_main_mem.sv
rtl/torcs_reg_file.sv
rtl/torcs_alu.sv
rtl/twelve_op_risc_core_step_core.sv
rtl/torcs_checker.sv
sim/testbench.sv
